// File: rtl/gbp_pkg.sv
// Package for the gshare branch predictor: sizes, command and mode codes,
// the queue entry type and the back-end state type.
// Depends on nothing; the modules and the testbench import it, and gbp_req_if uses its pc width.
package gbp_pkg;

    localparam int INDEX_BITS  = 12;
    localparam int TABLE_DEPTH = 1 << INDEX_BITS;
    localparam int PC_BITS     = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    typedef logic [INDEX_BITS-1:0] gbp_index_t;
    typedef logic [1:0]            gbp_ctr_t;

    localparam gbp_ctr_t CTR_MIN        = 2'd0;
    localparam gbp_ctr_t CTR_WEAK_TAKEN = 2'd2;
    localparam gbp_ctr_t CTR_MAX        = 2'd3;

    localparam logic CMD_PREDICT = 1'b0;
    localparam logic CMD_UPDATE  = 1'b1;

    localparam logic MODE_ALWAYS_TAKEN = 1'b0;
    localparam logic MODE_GSHARE       = 1'b1;

    typedef struct packed {
        logic       command;
        gbp_index_t index;
        logic       taken_outcome;
    } gbp_entry_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC
    } gbp_back_state_t;

endpackage

// File: rtl/gbp_req_if.sv
// Request channel of the gshare predictor: valid, ready and the item fields.
// Depends on gbp_pkg for the pc width.
interface gbp_req_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [gbp_pkg::PC_BITS-1:0] pc;
    logic                        taken_outcome;

    modport source (output valid, output command, output pc, output taken_outcome,
                    input ready);
    modport sink   (input valid, input command, input pc, input taken_outcome,
                    output ready);
endinterface

// File: rtl/gbp_rsp_if.sv
// Response channel of the gshare predictor: valid, ready and the prediction.
// Depends on nothing.
interface gbp_rsp_if;
    logic valid;
    logic ready;
    logic predict_taken;

    modport source (output valid, output predict_taken, input ready);
    modport sink   (input valid, input predict_taken, output ready);
endinterface

// File: rtl/gbp_cfg_if.sv
// Configuration write channel of the gshare predictor: valid, ready, mode.
// Depends on nothing.
interface gbp_cfg_if;
    logic valid;
    logic ready;
    logic mode;

    modport source (output valid, output mode, input ready);
    modport sink   (input valid, input mode, output ready);
endinterface

// File: rtl/gshare_branch_predictor.sv
// Top level of the gshare branch direction predictor.
// Depends on gbp_pkg, the three channel interfaces, gbp_front, gbp_queue and gbp_back.
//
// The block predicts branch directions from a table of 2-bit saturating
// counters indexed by the low pc bits XORed with a global history register.
// Request transactions arrive on req: command selects a prediction or an
// update with the resolved taken_outcome. Each prediction yields exactly one
// transaction on rsp carrying predict_taken; updates yield none. The cfg
// channel writes the mode bit (0 always taken, 1 gshare) and is always ready;
// it should only be written while no request is in flight.
//
// The front end updates the history as update requests are accepted and pushes
// every request into a four-entry queue. The back end takes the next queued
// request only when the last is done, since each needs a registered table read
// followed by the write or the answer. An answer waits while rsp is stalled.
//
// After reset the back end writes weakly taken into all 4096 table entries,
// one per cycle, and req.ready stays low until that pass is done. When rsp is
// stalled the answer holds in the output register; the queue keeps accepting
// requests until it fills, and then req.ready drops.
module gshare_branch_predictor (
    input  logic      clk,
    input  logic      rst_n,
    gbp_req_if.sink   req,
    gbp_rsp_if.source rsp,
    gbp_cfg_if.sink   cfg
);
    import gbp_pkg::*;

    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    logic       accept_en;
    gbp_entry_t push_entry;
    gbp_entry_t pop_entry;

    // Front end: handshake, history and index computation.
    gbp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .accept_en (accept_en),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (push_entry)
    );

    // Decoupling queue so that a stalled response does not stop acceptance.
    gbp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty)
    );

    // Back end: table clear, read-modify-write and the output register.
    gbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .rsp       (rsp),
        .q_empty   (q_empty),
        .q_entry   (pop_entry),
        .q_pop     (q_pop),
        .accept_en (accept_en)
    );

endmodule

// File: rtl/gbp_queue.sv
// Small FIFO between the front end and the back end of the predictor.
// Depends on gbp_pkg for the entry type and the queue depth.
module gbp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  gbp_pkg::gbp_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output gbp_pkg::gbp_entry_t pop_entry,
    output logic                empty
);
    import gbp_pkg::*;

    gbp_entry_t           entries_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]   count_reg,  count_next;
    logic                 do_push, do_pop;

    assign full      = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = entries_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: rtl/gbp_front.sv
// Front end of the predictor: accepts request transactions, keeps the global
// history and forms the table index. Depends on gbp_pkg and gbp_req_if.
module gbp_front (
    input  logic                clk,
    input  logic                rst_n,
    gbp_req_if.sink             req,
    input  logic                accept_en,
    input  logic                q_full,
    output logic                q_push,
    output gbp_pkg::gbp_entry_t q_entry
);
    import gbp_pkg::*;

    gbp_index_t hist_reg, hist_next;

    assign req.ready = accept_en && !q_full;
    assign q_push    = req.valid && req.ready;

    always_comb
    begin
        q_entry.command       = req.command;
        q_entry.index         = req.pc[INDEX_BITS-1:0] ^ hist_reg;
        q_entry.taken_outcome = req.taken_outcome;

        hist_next = hist_reg;
        if (q_push && req.command == CMD_UPDATE)
        begin
            hist_next = {hist_reg[INDEX_BITS-2:0], req.taken_outcome};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
        end
        else
        begin
            hist_reg <= hist_next;
        end
    end

endmodule

// File: rtl/gbp_back.sv
// Back end of the predictor: clears the counter table after reset, then reads,
// trains and answers from it. Depends on gbp_pkg, gbp_cfg_if and gbp_rsp_if.
module gbp_back (
    input  logic                clk,
    input  logic                rst_n,
    gbp_cfg_if.sink             cfg,
    gbp_rsp_if.source           rsp,
    input  logic                q_empty,
    input  gbp_pkg::gbp_entry_t q_entry,
    output logic                q_pop,
    output logic                accept_en
);
    import gbp_pkg::*;

    gbp_ctr_t        table_mem [TABLE_DEPTH];
    gbp_ctr_t        rd_data_reg;

    gbp_back_state_t state_reg, state_next;
    gbp_index_t      clr_idx_reg, clr_idx_next;
    gbp_entry_t      cur_reg, cur_next;
    logic            mode_reg;
    logic            out_valid_reg, out_valid_next;
    logic            out_taken_reg, out_taken_next;

    logic            rd_en;
    logic            wr_en;
    gbp_index_t      wr_addr;
    gbp_ctr_t        wr_data;
    logic            out_free;
    gbp_ctr_t        ctr_trained;

    assign cfg.ready         = 1'b1;
    assign rsp.valid         = out_valid_reg;
    assign rsp.predict_taken = out_taken_reg;
    assign accept_en         = (state_reg != BK_CLEAR);
    assign out_free          = !out_valid_reg || rsp.ready;

    always_comb
    begin
        if (cur_reg.taken_outcome)
        begin
            ctr_trained = (rd_data_reg == CTR_MAX) ? CTR_MAX : rd_data_reg + 2'd1;
        end
        else
        begin
            ctr_trained = (rd_data_reg == CTR_MIN) ? CTR_MIN : rd_data_reg - 2'd1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        out_taken_next = out_taken_reg;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = cur_reg.index;
        wr_data        = ctr_trained;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            BK_CLEAR:
            begin
                // One table entry is set to weakly taken per cycle.
                wr_en        = 1'b1;
                wr_addr      = clr_idx_reg;
                wr_data      = CTR_WEAK_TAKEN;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (&clr_idx_reg)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    rd_en      = 1'b1;
                    cur_next   = q_entry;
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                if (cur_reg.command == CMD_UPDATE)
                begin
                    wr_en      = 1'b1;
                    state_next = BK_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_taken_next = (mode_reg == MODE_ALWAYS_TAKEN) ? 1'b1
                                   : (rd_data_reg >= CTR_WEAK_TAKEN);
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_idx_reg   <= '0;
            mode_reg      <= MODE_GSHARE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                mode_reg <= cfg.mode;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        out_taken_reg <= out_taken_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= table_mem[q_entry.index];
        end
    end

endmodule

// File: sim/tb_gshare_branch_predictor.sv
// Self-checking testbench for the gshare branch predictor: directed and random request
// traffic, random stalls on both channels and mode changes between phases.
// Depends on gbp_pkg, the three channel interfaces and gshare_branch_predictor.
module tb_gshare_branch_predictor;
    import gbp_pkg::*;

    localparam int HALF_PERIOD   = 5;
    // The slowest correct run is the table clearing pass plus roughly 900 transactions.
    // Each of those can see a random gap, its service and a random stall. Add the
    // hold-off and the settle pauses, and the total stays far below the limit.
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 64;
    localparam int HOLD_ITEMS    = 24;
    localparam int POOL_SIZE     = 6;
    localparam int REPORT_LIMIT  = 10;

    // Outcome patterns for the synthetic branches of the random traffic.
    typedef enum int {
        PAT_TAKEN,
        PAT_NOT_TAKEN,
        PAT_LOOP,
        PAT_BIASED
    } branch_pattern_t;

    // Mirror of the predictor state. It keeps the history register, the counter
    // table and the mode bit, and it queues the direction that each accepted
    // prediction request must produce.
    class gshare_mirror;
        logic       mode;
        gbp_index_t history;
        gbp_ctr_t   counters [TABLE_DEPTH];
        logic       pending_taken [$];
        int         mismatches;
        int         checked;

        function void clear_state();
            mode    = MODE_GSHARE;
            history = '0;
            foreach (counters[i])
                counters[i] = CTR_WEAK_TAKEN;
            pending_taken.delete();
            mismatches = 0;
            checked    = 0;
        endfunction

        // Called once for every accepted request transaction.
        function void absorb_request(logic command, logic [PC_BITS-1:0] pc, logic outcome);
            gbp_index_t slot;
            slot = pc[INDEX_BITS-1:0] ^ history;
            if (command == CMD_PREDICT) begin
                if (mode == MODE_ALWAYS_TAKEN)
                    pending_taken.push_back(1'b1);
                else
                    pending_taken.push_back(counters[slot] >= CTR_WEAK_TAKEN);
            end
            else begin
                // The index uses the old history, and the outcome is shifted in afterward.
                history = {history[INDEX_BITS-2:0], outcome};
                if (outcome) begin
                    if (counters[slot] != CTR_MAX)
                        counters[slot] = counters[slot] + 2'd1;
                end
                else if (counters[slot] != CTR_MIN) begin
                    counters[slot] = counters[slot] - 2'd1;
                end
            end
        endfunction

        // Called once for every accepted response transaction.
        function void check_prediction(logic actual);
            logic want;
            if (pending_taken.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] unexpected prediction transaction: predict_taken=%b",
                             $time, actual);
                return;
            end
            want = pending_taken.pop_front();
            checked++;
            if (actual !== want) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] predict_taken mismatch on prediction %0d: expected %b, got %b",
                             $time, checked, want, actual);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    int unsigned cycle_count = 0;

    // gaps_on steers the sender, stalls_on the receiver; hold_ask is shared by both processes.
    bit gaps_on   = 1'b1;
    bit stalls_on = 1'b1;
    bit hold_ask  = 1'b0;

    int n_predicts    = 0;
    int n_updates     = 0;
    int n_mode_writes = 0;
    int n_holds       = 0;

    gshare_mirror mirror;

    gbp_req_if req_ch ();
    gbp_rsp_if rsp_ch ();
    gbp_cfg_if cfg_ch ();

    gshare_branch_predictor i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // Watchdog. A hung handshake must not run forever.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d predictions outstanding.",
                     cycle_count, mirror.pending_taken.size());
            $display("FAIL gshare_branch_predictor");
            $finish;
        end
    end

    // Monitor. All three channels are sampled at the rising edge, before any
    // nonblocking update of that edge lands. A mode write and a request are never
    // accepted at the same edge, so the order inside this block does not matter.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                mirror.mode = cfg_ch.mode;
                n_mode_writes++;
            end
            if (req_ch.valid && req_ch.ready) begin
                mirror.absorb_request(req_ch.command, req_ch.pc, req_ch.taken_outcome);
                if (req_ch.command == CMD_PREDICT)
                    n_predicts++;
                else
                    n_updates++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
                mirror.check_prediction(rsp_ch.predict_taken);
        end
    end

    // Response receiver. While stalls_on is set, runs of ready alternate with short random stalls. On
    // request it holds ready low for a long stretch, so that the output register
    // and the queue fill up and the block drops req.ready.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (hold_ask) begin
                hold_ask = 1'b0;
                n_holds++;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (stalls_on && $urandom_range(0, 3) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // Offers one request transaction and returns at the edge where it is accepted.
    // Valid stays high on return. The next call either keeps it high with a new
    // payload or drops it for a gap, so valid never gets two assignments in one step.
    task automatic offer_request(input logic command, input logic [PC_BITS-1:0] pc,
                                 input logic outcome);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.command       <= command;
        req_ch.pc            <= pc;
        req_ch.taken_outcome <= outcome;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Stops offering, waits until every prediction has been answered, and then
    // allows time for queued updates, which produce no response, to retire.
    task automatic wait_for_quiet();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (mirror.pending_taken.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the mode register. The caller makes sure the block is idle.
    task automatic write_mode(input logic value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.mode  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Hand-picked sequence. Its pc values follow the history as it evolves, so
    // the same counter is hit again and again. It covers the extreme pc values,
    // pc bits above the index that must be ignored, saturation at both ends,
    // predictions that leave the state alone, and training while always-taken
    // mode is on.
    task automatic run_directed();
        int k;
        // Reset state: every counter is weakly taken and the history is zero.
        offer_request(CMD_PREDICT, 64'h0, 1'b0);
        offer_request(CMD_PREDICT, '1, 1'b1);
        // Drive counter 0 down to the floor. The history stays zero, and the
        // second update reaches the same counter through a pc with high bits set.
        offer_request(CMD_UPDATE, 64'h0, 1'b0);
        offer_request(CMD_UPDATE, 64'hFFFF_FFFF_FFFF_F000, 1'b0);
        offer_request(CMD_UPDATE, 64'h0, 1'b0);
        offer_request(CMD_PREDICT, 64'h8000_0000_0000_0000, 1'b1);
        // Push counter 0xABC to the ceiling. Each pc cancels the history that the
        // previous taken outcomes have built up (0, 1, 3, 7).
        offer_request(CMD_UPDATE, 64'h0ABC, 1'b1);
        offer_request(CMD_UPDATE, 64'h0ABD, 1'b1);
        offer_request(CMD_UPDATE, 64'h0ABF, 1'b1);
        offer_request(CMD_UPDATE, 64'h0ABB, 1'b1);
        offer_request(CMD_PREDICT, 64'h0AB3, 1'b0);
        // One not-taken step down from the ceiling, then read it back with history 0x1E.
        offer_request(CMD_UPDATE, 64'h0AB3, 1'b0);
        offer_request(CMD_PREDICT, 64'h0AA2, 1'b1);
        wait_for_quiet();

        // Always-taken mode: answers ignore the table, but training goes on.
        write_mode(MODE_ALWAYS_TAKEN);
        offer_request(CMD_PREDICT, 64'h001E, 1'b0);
        offer_request(CMD_UPDATE, 64'h001E, 1'b1);
        offer_request(CMD_UPDATE, 64'h003D, 1'b1);
        offer_request(CMD_PREDICT, '1, 1'b0);
        wait_for_quiet();

        // Back in gshare mode, counter 0 must show the two taken updates made above.
        write_mode(MODE_GSHARE);
        offer_request(CMD_PREDICT, 64'h007B, 1'b0);
        for (k = 0; k < 6; k++)
            offer_request(CMD_UPDATE, {$urandom, $urandom}, k[0]);
        wait_for_quiet();
    endtask

    // Random traffic. Most of it imitates a program: a small pool of branches,
    // each with its own outcome pattern, executed in runs of predict-then-update
    // pairs. Long runs of one branch make the history periodic, so the same
    // counters are trained until they saturate. The rest is noise: random
    // commands, full 64-bit pcs and random outcomes, and with_hold adds a burst of predictions into a long hold-off.
    task automatic run_traffic(input int n_items, input bit with_hold);
        logic [INDEX_BITS-1:0] spots [POOL_SIZE];
        branch_pattern_t       styles [POOL_SIZE];
        int                    trips [POOL_SIZE];
        int                    period [POOL_SIZE];
        logic [PC_BITS-1:0]    pc;
        logic                  outcome;
        int                    sent;
        int                    k;
        int                    run;
        int                    n;
        bit                    held;

        for (k = 0; k < POOL_SIZE; k++) begin
            spots[k]  = INDEX_BITS'($urandom);
            styles[k] = branch_pattern_t'($urandom_range(0, 3));
            trips[k]  = 0;
            period[k] = $urandom_range(2, 6);
        end
        spots[0] = '0;
        spots[1] = '1;
        sent = 0;
        held = 1'b0;

        while (sent < n_items) begin
            if (with_hold && !held && sent >= n_items / 2) begin
                // Ask for the long hold-off, then keep offering predictions into it.
                held     = 1'b1;
                hold_ask = 1'b1;
                for (n = 0; n < HOLD_ITEMS; n++)
                    offer_request(CMD_PREDICT, {$urandom, $urandom},
                                  1'($urandom_range(0, 1)));
                sent += HOLD_ITEMS;
            end
            else if ($urandom_range(0, 9) < 7) begin
                k   = $urandom_range(0, POOL_SIZE - 1);
                run = $urandom_range(1, 12);
                for (n = 0; n < run; n++) begin
                    pc = {$urandom, $urandom};
                    pc[INDEX_BITS-1:0] = spots[k];
                    case (styles[k])
                        PAT_TAKEN:     outcome = 1'b1;
                        PAT_NOT_TAKEN: outcome = 1'b0;
                        PAT_LOOP:      outcome = (trips[k] % period[k]) != period[k] - 1;
                        default:       outcome = $urandom_range(0, 7) != 0;
                    endcase
                    trips[k]++;
                    offer_request(CMD_PREDICT, pc, 1'($urandom_range(0, 1)));
                    offer_request(CMD_UPDATE, pc, outcome);
                    sent += 2;
                end
            end
            else begin
                run = $urandom_range(1, 4);
                for (n = 0; n < run; n++)
                    offer_request(1'($urandom_range(0, 1)), {$urandom, $urandom},
                                  1'($urandom_range(0, 1)));
                sent += run;
            end
        end
        wait_for_quiet();
    endtask

    // Main sequence: reset, the directed part, then four random phases. Mode
    // writes happen only between phases, once the block has gone quiet. The
    // last phase runs with no gaps and no stalls.
    initial
    begin
        mirror = new;
        mirror.clear_state();
        rst_n                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.command       <= CMD_PREDICT;
        req_ch.pc            <= '0;
        req_ch.taken_outcome <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.mode          <= MODE_GSHARE;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // The first request waits out the table clearing pass on req.ready.
        run_directed();

        write_mode(MODE_GSHARE);
        run_traffic(260, 1'b1);
        write_mode(MODE_ALWAYS_TAKEN);
        run_traffic(180, 1'b0);
        write_mode(MODE_GSHARE);
        run_traffic(200, 1'b0);

        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        run_traffic(160, 1'b0);

        $display("Covered %0d predictions and %0d updates across %0d mode writes in both modes,",
                 n_predicts, n_updates, n_mode_writes);
        $display("with random gaps and stalls and %0d long response hold-off; %0d mismatches.",
                 n_holds, mirror.mismatches);
        if (mirror.mismatches == 0 && mirror.pending_taken.size() == 0)
            $display("PASS gshare_branch_predictor");
        else
            $display("FAIL gshare_branch_predictor");
        $finish;
    end

endmodule
